[src/rpp_pkg.sv]
// shared types and constants for the rip packet parser
`timescale 1ns / 1ps

package rpp_pkg;

  localparam int unsigned ENTRY_LEN = 20;
  localparam int unsigned HDR_LEN   = 4;

  localparam logic [15:0] AUTH_FAMILY      = 16'hFFFF;
  localparam logic [9:0]  MAX_ROUTES_RESET = 10'd50;
  localparam logic [11:0] FULL_COUNT_MAX   = 12'hFFF;

  localparam logic [7:0] CMD_MIN = 8'd1;
  localparam logic [7:0] CMD_MAX = 8'd5;
  localparam logic [7:0] VER_ONE = 8'd1;
  localparam logic [7:0] VER_TWO = 8'd2;

  // flag bit positions
  localparam int unsigned FLAG_V1_ENTRY   = 0;
  localparam int unsigned FLAG_FULL_TABLE = 1;
  localparam int unsigned FLAG_V1_HDR_NZ  = 2;
  localparam int unsigned FLAG_TRUNCATED  = 3;
  localparam int unsigned FLAG_LEFTOVER   = 4;

  typedef enum logic [1:0] {
    KIND_ROUTE  = 2'd0,
    KIND_AUTH   = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_REJECT = 2'd3
  } item_kind_e;

  typedef struct packed {
    item_kind_e  item_kind;
    logic [2:0]  command;
    logic [1:0]  version;
    logic [15:0] addr_family;
    logic [15:0] tag_or_auth_type;
    logic [31:0] word_zero;
    logic [31:0] word_one;
    logic [31:0] word_two;
    logic [31:0] word_three;
    logic [4:0]  flags;
    logic [9:0]  entry_count;
    logic        last_of_run;
  } res_t;

endpackage

[src/rpp_out_queue.sv]
// two-slot result buffer, takes up to two words per cycle while room_o is high and gives one
`timescale 1ns / 1ps

module rpp_out_queue
  import rpp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  res_t       push0_i,
  input  res_t       push1_i,
  output logic       room_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output res_t       head_o
);

  logic [1:0] count_q, count_d;
  logic [1:0] base;
  logic       pop;
  res_t       slot0_q, slot0_d;
  res_t       slot1_q, slot1_d;

  assign out_valid_o = (count_q != 2'd0);
  assign head_o      = slot0_q;
  assign pop         = out_valid_o && out_ready_i;
  // room for two words even when both come from one byte
  assign room_o      = (count_q == 2'd0) || ((count_q == 2'd1) && out_ready_i);

  always_comb begin
    base    = count_q - {1'b0, pop};
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop) begin
      slot0_d = slot1_q;
    end
    if (push_cnt_i != 2'd0) begin
      if (base == 2'd0) begin
        slot0_d = push0_i;
      end else begin
        slot1_d = push0_i;
      end
    end
    if (push_cnt_i == 2'd2) begin
      slot1_d = push1_i;
    end
    count_d = base + push_cnt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

[src/rip_packet_parser.sv]
// rip message parser: header check, entry split and per-message status
// result words: each is written into the registered output buffer when its byte is accepted
// throughput: one byte per cycle while out_ready_i is high; a last byte that also closes an entry gives
//   two words, and the two-slot output buffer then holds input off while they wait
// reset: message state cleared, max_routes set to 50, output buffer empty
`timescale 1ns / 1ps

module rip_packet_parser
  import rpp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_max_routes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  item_kind_o,
  output logic [2:0]  command_o,
  output logic [1:0]  version_o,
  output logic [15:0] addr_family_o,
  output logic [15:0] tag_or_auth_type_o,
  output logic [31:0] word_zero_o,
  output logic [31:0] word_one_o,
  output logic [31:0] word_two_o,
  output logic [31:0] word_three_o,
  output logic [4:0]  flags_o,
  output logic [9:0]  entry_count_o,
  output logic        last_of_run_o
);

  localparam logic [4:0] HdrLen   = 5'(HDR_LEN);
  localparam logic [4:0] EntryLen = 5'(ENTRY_LEN);

  logic [9:0]  max_routes_q;
  logic [4:0]  pos_q, pos_d;
  logic        hdr_done_q, hdr_done_d;
  logic        rejected_q, rejected_d;
  logic [2:0]  cmd_q, cmd_d;
  logic [1:0]  ver_q, ver_d;
  logic        hdr_nz_q, hdr_nz_d;
  logic [11:0] full_q, full_d;
  logic [9:0]  dec_q, dec_d;
  logic [9:0]  auth_q, auth_d;
  // entry bytes 0..18 shift in; byte 19 comes straight from the input
  logic [7:0]  ent_q [ENTRY_LEN-1];
  logic        shift_en;

  logic        accept;
  logic        room;
  logic [1:0]  push_cnt;
  res_t        push0, push1;
  res_t        ent_res, fin_res, head;

  // working copies of message state for this byte
  logic [4:0]  pos_w, pos_inc;
  logic        hd_w, rej_w, nz_w, emit_w;
  logic [2:0]  cmd_w;
  logic [1:0]  ver_w;
  logic [11:0] full_w;
  logic [9:0]  dec_w, auth_w;
  logic        is_auth;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = room;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    pos_w    = pos_q;
    hd_w     = hdr_done_q;
    rej_w    = rejected_q;
    cmd_w    = cmd_q;
    ver_w    = ver_q;
    nz_w     = hdr_nz_q;
    full_w   = full_q;
    dec_w    = dec_q;
    auth_w   = auth_q;
    emit_w   = 1'b0;
    shift_en = 1'b0;
    pos_inc  = pos_q + 5'd1;
    is_auth  = ({ent_q[0], ent_q[1]} == AUTH_FAMILY);

    if (!hdr_done_q) begin
      if (pos_q == 5'd0) begin
        cmd_w = data_byte_i[2:0];
        if (data_byte_i < CMD_MIN || data_byte_i > CMD_MAX) begin
          rej_w = 1'b1;
        end
      end else if (pos_q == 5'd1) begin
        ver_w = data_byte_i[1:0];
        if (data_byte_i != VER_ONE && data_byte_i != VER_TWO) begin
          rej_w = 1'b1;
        end
      end else if (data_byte_i != 8'd0) begin
        nz_w = 1'b1;
      end
      pos_w = pos_inc;
      if (pos_inc >= HdrLen) begin
        hd_w  = 1'b1;
        pos_w = 5'd0;
      end
    end else if (!rejected_q) begin
      shift_en = 1'b1;
      pos_w    = (pos_q >= EntryLen) ? 5'd1 : pos_inc;
      if (pos_w == EntryLen) begin
        pos_w = 5'd0;
        if (full_q != FULL_COUNT_MAX) begin
          full_w = full_q + 12'd1;
        end
        if (dec_q < max_routes_q) begin
          emit_w = 1'b1;
          dec_w  = dec_q + 10'd1;
          if (is_auth) begin
            auth_w = auth_q + 10'd1;
          end
        end
      end
    end
  end

  // entry word, valid when the current byte closes an entry
  always_comb begin
    ent_res                  = '0;
    ent_res.item_kind        = is_auth ? KIND_AUTH : KIND_ROUTE;
    ent_res.command          = cmd_q;
    ent_res.version          = ver_q;
    ent_res.addr_family      = {ent_q[0], ent_q[1]};
    ent_res.tag_or_auth_type = {ent_q[2], ent_q[3]};
    ent_res.word_zero        = {ent_q[4], ent_q[5], ent_q[6], ent_q[7]};
    ent_res.word_one         = {ent_q[8], ent_q[9], ent_q[10], ent_q[11]};
    ent_res.word_two         = {ent_q[12], ent_q[13], ent_q[14], ent_q[15]};
    ent_res.word_three       = {ent_q[16], ent_q[17], ent_q[18], data_byte_i};
    ent_res.entry_count      = dec_w;
    ent_res.last_of_run      = !last_byte_i;
    if (!is_auth) begin
      ent_res.flags[FLAG_FULL_TABLE] = (ent_res.addr_family == 16'd0);
      ent_res.flags[FLAG_V1_ENTRY]   = (ver_q == 2'd1) &&
          ((ent_res.tag_or_auth_type != 16'd0) || (ent_res.word_one != 32'd0) ||
           (ent_res.word_two != 32'd0));
    end
  end

  // status or reject word for the last byte
  always_comb begin
    fin_res             = '0;
    fin_res.last_of_run = 1'b1;
    if (!hd_w || rej_w) begin
      fin_res.item_kind = KIND_REJECT;
    end else begin
      fin_res.item_kind             = KIND_STATUS;
      fin_res.command               = cmd_w;
      fin_res.version               = ver_w;
      fin_res.word_zero             = {20'd0, full_w};
      fin_res.word_one              = {27'd0, pos_w};
      fin_res.word_two              = {22'd0, auth_w};
      fin_res.flags[FLAG_V1_HDR_NZ] = (ver_w == 2'd1) && nz_w;
      fin_res.flags[FLAG_TRUNCATED] = (full_w > {2'b00, max_routes_q});
      fin_res.flags[FLAG_LEFTOVER]  = (pos_w != 5'd0);
      fin_res.entry_count           = dec_w;
    end
  end

  always_comb begin
    push_cnt = 2'd0;
    push0    = fin_res;
    push1    = fin_res;
    if (accept) begin
      if (emit_w) begin
        push0    = ent_res;
        push_cnt = last_byte_i ? 2'd2 : 2'd1;
      end else if (last_byte_i) begin
        push_cnt = 2'd1;
      end
    end
  end

  always_comb begin
    pos_d      = pos_q;
    hdr_done_d = hdr_done_q;
    rejected_d = rejected_q;
    cmd_d      = cmd_q;
    ver_d      = ver_q;
    hdr_nz_d   = hdr_nz_q;
    full_d     = full_q;
    dec_d      = dec_q;
    auth_d     = auth_q;
    if (accept) begin
      if (last_byte_i) begin
        pos_d      = 5'd0;
        hdr_done_d = 1'b0;
        rejected_d = 1'b0;
        cmd_d      = 3'd0;
        ver_d      = 2'd0;
        hdr_nz_d   = 1'b0;
        full_d     = 12'd0;
        dec_d      = 10'd0;
        auth_d     = 10'd0;
      end else begin
        pos_d      = pos_w;
        hdr_done_d = hd_w;
        rejected_d = rej_w;
        cmd_d      = cmd_w;
        ver_d      = ver_w;
        hdr_nz_d   = nz_w;
        full_d     = full_w;
        dec_d      = dec_w;
        auth_d     = auth_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_routes_q <= MAX_ROUTES_RESET;
      pos_q        <= 5'd0;
      hdr_done_q   <= 1'b0;
      rejected_q   <= 1'b0;
      cmd_q        <= 3'd0;
      ver_q        <= 2'd0;
      hdr_nz_q     <= 1'b0;
      full_q       <= 12'd0;
      dec_q        <= 10'd0;
      auth_q       <= 10'd0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_routes_q <= cfg_max_routes_i;
      end
      pos_q      <= pos_d;
      hdr_done_q <= hdr_done_d;
      rejected_q <= rejected_d;
      cmd_q      <= cmd_d;
      ver_q      <= ver_d;
      hdr_nz_q   <= hdr_nz_d;
      full_q     <= full_d;
      dec_q      <= dec_d;
      auth_q     <= auth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && shift_en) begin
      for (int i = 0; i < ENTRY_LEN - 2; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
      ent_q[ENTRY_LEN-2] <= data_byte_i;
    end
  end

  rpp_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push0_i     (push0),
    .push1_i     (push1),
    .room_o      (room),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .head_o      (head)
  );

  assign item_kind_o        = head.item_kind;
  assign command_o          = head.command;
  assign version_o          = head.version;
  assign addr_family_o      = head.addr_family;
  assign tag_or_auth_type_o = head.tag_or_auth_type;
  assign word_zero_o        = head.word_zero;
  assign word_one_o         = head.word_one;
  assign word_two_o         = head.word_two;
  assign word_three_o       = head.word_three;
  assign flags_o            = head.flags;
  assign entry_count_o      = head.entry_count;
  assign last_of_run_o      = head.last_of_run;

  // input is held off only while words wait at the output
  a_stall_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output buffer");

  // a last byte always leaves a word behind
  a_last_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_byte_i) |=> out_valid_o)
    else $error("last byte gave no word");

  a_status_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (item_kind_o == KIND_STATUS || item_kind_o == KIND_REJECT))
      |-> last_of_run_o)
    else $error("status or reject word not marked last");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && item_kind_o == KIND_REJECT)
      |-> (command_o == 3'd0 && entry_count_o == 10'd0 && flags_o == 5'd0))
    else $error("reject word carries data");

endmodule
